/* rtl/core/arpp_pkg.sv */
// shared types, constants and packing for the ARP payload header parser
// no dependencies; used by every module under rtl/core

package arpp_pkg;

	// byte counter and frame layout
	localparam int unsigned CountWidth = 11;
	localparam logic [CountWidth-1:0] COUNT_MAX = 11'd2047;
	localparam logic [CountWidth-1:0] HDR_LEN = 11'd8;
	localparam logic [CountWidth-1:0] SMAC_END = 11'd14;
	localparam logic [CountWidth-1:0] SIP_END = 11'd18;
	localparam logic [CountWidth-1:0] TMAC_END = 11'd24;
	localparam logic [CountWidth-1:0] TIP_END = 11'd28;

	// header field values
	localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
	localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
	localparam logic [7:0] HLEN_ETHERNET = 8'd6;
	localparam logic [7:0] PLEN_IPV4 = 8'd4;
	localparam logic [15:0] OP_MIN = 16'd1;
	localparam logic [15:0] OP_MAX = 16'd25;
	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY = 16'd2;

	// bit positions in kind_flags
	localparam int unsigned KIND_GRATUITOUS = 0;
	localparam int unsigned KIND_PROBE = 1;
	localparam int unsigned KIND_ANNOUNCE = 2;

	// width of the result item on the master side, padded to whole bytes
	localparam int unsigned ResultBits = 229;
	localparam int unsigned ResultTdataWidth = ((ResultBits + 7) / 8) * 8;

	// capture state after the current byte has been taken in
	typedef struct packed {
		logic [CountWidth-1:0] count;
		logic [63:0]           hdr;
		logic [47:0]           smac;
		logic [31:0]           sip;
		logic [47:0]           tmac;
		logic [31:0]           tip;
	} capt_t;

	// one verdict item
	typedef struct packed {
		logic [2:0]  kind_flags;
		logic [31:0] target_ip;
		logic [47:0] target_mac;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic        eth_ipv4;
		logic [7:0]  proto_len;
		logic [7:0]  hw_len;
		logic [15:0] proto_type;
		logic [15:0] hw_type;
		logic [15:0] opcode;
		logic        accepted;
	} result_t;

	// pack a verdict into tdata, last field in the lowest bits
	function automatic logic [ResultTdataWidth-1:0] pack_result(input result_t r);
		logic [ResultTdataWidth-1:0] d;
		d = '0;
		d[ResultBits-1:0] = r;
		return d;
	endfunction

endpackage

/* rtl/core/arpp_capture.sv */
// byte counter and capture registers for the ARP payload header parser
// depends on arpp_pkg; gives the state as it stands after the current byte

module arpp_capture (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,      // a byte is taken in this cycle
	input  logic                 frame_end, // that byte closes the frame
	input  logic [7:0]           data_byte,
	output arpp_pkg::capt_t      capt_next
);

	logic [arpp_pkg::CountWidth-1:0] count_q;
	logic [63:0] hdr_q;
	logic [47:0] smac_q;
	logic [31:0] sip_q;
	logic [47:0] tmac_q;
	logic [31:0] tip_q;

	// route the byte to the field its position selects
	always_comb begin
		capt_next.count = (count_q == arpp_pkg::COUNT_MAX) ? count_q
			: count_q + arpp_pkg::CountWidth'(1);
		capt_next.hdr = hdr_q;
		capt_next.smac = smac_q;
		capt_next.sip = sip_q;
		capt_next.tmac = tmac_q;
		capt_next.tip = tip_q;
		priority if (count_q < arpp_pkg::HDR_LEN) begin
			capt_next.hdr = {hdr_q[55:0], data_byte};
		end else if (count_q < arpp_pkg::SMAC_END) begin
			capt_next.smac = {smac_q[39:0], data_byte};
		end else if (count_q < arpp_pkg::SIP_END) begin
			capt_next.sip = {sip_q[23:0], data_byte};
		end else if (count_q < arpp_pkg::TMAC_END) begin
			capt_next.tmac = {tmac_q[39:0], data_byte};
		end else if (count_q < arpp_pkg::TIP_END) begin
			capt_next.tip = {tip_q[23:0], data_byte};
		end else begin
			// bytes past the target address are not kept
		end
	end

	// state registers, cleared at the end of every frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hdr_q <= '0;
			smac_q <= '0;
			sip_q <= '0;
			tmac_q <= '0;
			tip_q <= '0;
		end else if (fire) begin
			if (frame_end) begin
				count_q <= '0;
				hdr_q <= '0;
				smac_q <= '0;
				sip_q <= '0;
				tmac_q <= '0;
				tip_q <= '0;
			end else begin
				count_q <= capt_next.count;
				hdr_q <= capt_next.hdr;
				smac_q <= capt_next.smac;
				sip_q <= capt_next.sip;
				tmac_q <= capt_next.tmac;
				tip_q <= capt_next.tip;
			end
		end
	end

	// frame end leaves a clean slate
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && frame_end |=> count_q == '0 && hdr_q == '0 && sip_q == '0 && tip_q == '0)
		else $error("capture state not cleared after frame end");

	// counter only moves when a byte is taken
	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q))
		else $error("byte counter moved without an item");

	// counter never wraps back to zero mid-frame
	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !frame_end && count_q == arpp_pkg::COUNT_MAX |=> count_q == arpp_pkg::COUNT_MAX)
		else $error("byte counter wrapped");

endmodule

/* rtl/core/arpp_verdict.sv */
// length, opcode and layout checks that turn the captured header into a verdict
// depends on arpp_pkg; purely combinational

module arpp_verdict (
	input  arpp_pkg::capt_t   capt,
	output arpp_pkg::result_t verdict
);

	logic [15:0] htype;
	logic [15:0] ptype;
	logic [7:0]  hlen;
	logic [7:0]  plen;
	logic [15:0] op;
	logic [arpp_pkg::CountWidth-1:0] need;
	logic pass;
	logic eth;
	logic same_ip;

	// header fields, big-endian
	assign htype = capt.hdr[63:48];
	assign ptype = capt.hdr[47:32];
	assign hlen = capt.hdr[31:24];
	assign plen = capt.hdr[23:16];
	assign op = capt.hdr[15:0];

	// header plus both address pairs, at most 1028
	assign need = arpp_pkg::HDR_LEN + {2'b00, hlen, 1'b0} + {2'b00, plen, 1'b0};

	assign pass = (capt.count >= arpp_pkg::HDR_LEN) && (op >= arpp_pkg::OP_MIN)
		&& (op <= arpp_pkg::OP_MAX) && (capt.count >= need);
	assign eth = pass && (htype == arpp_pkg::HTYPE_ETHERNET) && (ptype == arpp_pkg::PTYPE_IPV4)
		&& (hlen == arpp_pkg::HLEN_ETHERNET) && (plen == arpp_pkg::PLEN_IPV4);
	assign same_ip = (capt.sip == capt.tip);

	// fields are zero unless the frame passes, addresses zero unless ethernet/ipv4
	always_comb begin
		verdict = '0;
		verdict.accepted = pass;
		if (pass) begin
			verdict.opcode = op;
			verdict.hw_type = htype;
			verdict.proto_type = ptype;
			verdict.hw_len = hlen;
			verdict.proto_len = plen;
		end
		if (eth) begin
			verdict.eth_ipv4 = 1'b1;
			verdict.sender_mac = capt.smac;
			verdict.sender_ip = capt.sip;
			verdict.target_mac = capt.tmac;
			verdict.target_ip = capt.tip;
			verdict.kind_flags[arpp_pkg::KIND_GRATUITOUS] =
				(op == arpp_pkg::OP_REQUEST || op == arpp_pkg::OP_REPLY) && same_ip;
			verdict.kind_flags[arpp_pkg::KIND_PROBE] =
				(op == arpp_pkg::OP_REQUEST) && (capt.sip == '0);
			verdict.kind_flags[arpp_pkg::KIND_ANNOUNCE] =
				(op == arpp_pkg::OP_REQUEST) && same_ip;
		end
	end

endmodule

/* rtl/core/arp_packet_parser.sv */
// ARP payload header parser: takes one payload byte per item and gives one
// verdict item per frame. A byte can be taken every cycle; each byte is held
// in the input register, where the counter and capture registers update,
// and the verdict for the last byte is loaded into the result register as that
// byte leaves. Only a last byte waits, and only while the result register still
// holds a verdict not yet taken. Depends on arpp_pkg, arpp_capture and
// arpp_verdict.

module arp_packet_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // payload_byte [7:0]
	input  logic         s_axis_tlast,  // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// accepted [0], opcode [16:1], hw_type [32:17], proto_type [48:33],
	// hw_len [56:49], proto_len [64:57], eth_ipv4 [65], sender_mac [113:66],
	// sender_ip [145:114], target_mac [193:146], target_ip [225:194],
	// kind_flags [228:226], zero [231:229]
	output logic [arpp_pkg::ResultTdataWidth-1:0] m_axis_tdata
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic [arpp_pkg::ResultTdataWidth-1:0] out_data_q;
	logic       out_free;
	logic       go_s1;
	arpp_pkg::capt_t   capt_next;
	arpp_pkg::result_t verdict;

	// a last byte needs the result register, other bytes never wait
	assign out_free = !out_valid_q || m_axis_tready;
	assign go_s1 = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || go_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			byte_s1 <= '0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			last_s1 <= s_axis_tlast;
			byte_s1 <= s_axis_tdata;
		end
	end

	// counter and field capture
	arpp_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (go_s1),
		.frame_end (last_s1),
		.data_byte (byte_s1),
		.capt_next (capt_next)
	);

	// checks and verdict
	arpp_verdict u_verdict (
		.capt    (capt_next),
		.verdict (verdict)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			out_data_q <= arpp_pkg::pack_result(verdict);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// a rejected frame carries nothing but the zero verdict
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[arpp_pkg::ResultTdataWidth-1:1] == '0)
		else $error("rejected frame with non-zero fields");

	// address layout only reported for accepted frames, flags only for that layout
	a_eth_needs_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[65] || m_axis_tdata[228:226] != '0)
			|-> m_axis_tdata[0] && m_axis_tdata[65])
		else $error("ethernet fields on a rejected frame or flags without layout");

	// a stalled last byte stays put in the input register
	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !out_free |=> valid_s1 && last_s1 && $stable(byte_s1))
		else $error("last byte lost while result register full");

	// a new verdict never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> $stable(out_data_q))
		else $error("waiting verdict overwritten");

endmodule

/* test/arp_packet_parser_test.sv */
// self-checking testbench for the ARP payload header parser (arp_packet_parser)
// drives payload bytes as frames with random stalls and checks each verdict item
// against its own frame predictor; depends on arpp_pkg and the parser RTL only
`timescale 1ns / 1ps

// frame predictor and store of pending verdicts
class verdict_board;
	logic [arpp_pkg::CountWidth-1:0] nbytes;
	logic [63:0] hdr;
	logic [47:0] smac, tmac;
	logic [31:0] sip, tip;
	arpp_pkg::result_t verdicts[$];
	int n_frames, n_accepted, n_eth, n_flagged, n_checked, n_failed;

	function new();
		clear();
	endfunction

	function void clear();
		nbytes = '0;
		hdr = '0;
		smac = '0;
		tmac = '0;
		sip = '0;
		tip = '0;
	endfunction

	function int pending();
		return verdicts.size();
	endfunction

	// take one accepted payload byte; a last byte queues one verdict
	function void note_byte(input logic [7:0] b, input logic last);
		arpp_pkg::result_t r;
		logic [15:0] op;
		int need;
		if (nbytes < arpp_pkg::HDR_LEN)
			hdr = {hdr[55:0], b};
		else if (nbytes < arpp_pkg::SMAC_END)
			smac = {smac[39:0], b};
		else if (nbytes < arpp_pkg::SIP_END)
			sip = {sip[23:0], b};
		else if (nbytes < arpp_pkg::TMAC_END)
			tmac = {tmac[39:0], b};
		else if (nbytes < arpp_pkg::TIP_END)
			tip = {tip[23:0], b};
		if (nbytes != arpp_pkg::COUNT_MAX)
			nbytes = nbytes + 1'b1;
		if (!last)
			return;
		r = '0;
		op = hdr[15:0];
		need = int'(arpp_pkg::HDR_LEN) + 2 * int'(hdr[31:24]) + 2 * int'(hdr[23:16]);
		if (nbytes >= arpp_pkg::HDR_LEN && op >= arpp_pkg::OP_MIN && op <= arpp_pkg::OP_MAX
				&& int'(nbytes) >= need) begin
			r.accepted = 1'b1;
			r.opcode = op;
			r.hw_type = hdr[63:48];
			r.proto_type = hdr[47:32];
			r.hw_len = hdr[31:24];
			r.proto_len = hdr[23:16];
			r.eth_ipv4 = (r.hw_type == arpp_pkg::HTYPE_ETHERNET &&
				r.proto_type == arpp_pkg::PTYPE_IPV4 &&
				r.hw_len == arpp_pkg::HLEN_ETHERNET && r.proto_len == arpp_pkg::PLEN_IPV4);
			// addresses and kind only for the ethernet/ipv4 layout
			if (r.eth_ipv4) begin
				r.sender_mac = smac;
				r.sender_ip = sip;
				r.target_mac = tmac;
				r.target_ip = tip;
				r.kind_flags[arpp_pkg::KIND_GRATUITOUS] =
					(op == arpp_pkg::OP_REQUEST || op == arpp_pkg::OP_REPLY) && sip == tip;
				r.kind_flags[arpp_pkg::KIND_PROBE] = (op == arpp_pkg::OP_REQUEST) && sip == '0;
				r.kind_flags[arpp_pkg::KIND_ANNOUNCE] = (op == arpp_pkg::OP_REQUEST) && sip == tip;
				n_eth++;
				if (r.kind_flags != '0)
					n_flagged++;
			end
			n_accepted++;
		end
		n_frames++;
		verdicts.insert(verdicts.size(), r);
		clear();
	endfunction

	function void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_failed++;
		end
	endfunction

	// compare one verdict item with the oldest pending one
	function void check_verdict(input logic [arpp_pkg::ResultTdataWidth-1:0] d);
		arpp_pkg::result_t got, want;
		if (verdicts.size() == 0) begin
			$error("verdict item with none pending: 0x%0h", d);
			n_failed++;
			return;
		end
		want = verdicts.pop_front();
		got = d[arpp_pkg::ResultBits-1:0];
		n_checked++;
		compare_field("accepted", want.accepted, got.accepted);
		compare_field("opcode", want.opcode, got.opcode);
		compare_field("hw_type", want.hw_type, got.hw_type);
		compare_field("proto_type", want.proto_type, got.proto_type);
		compare_field("hw_len", want.hw_len, got.hw_len);
		compare_field("proto_len", want.proto_len, got.proto_len);
		compare_field("eth_ipv4", want.eth_ipv4, got.eth_ipv4);
		compare_field("sender_mac", want.sender_mac, got.sender_mac);
		compare_field("sender_ip", want.sender_ip, got.sender_ip);
		compare_field("target_mac", want.target_mac, got.target_mac);
		compare_field("target_ip", want.target_ip, got.target_ip);
		compare_field("kind_flags", want.kind_flags, got.kind_flags);
		compare_field("padding", '0, d[arpp_pkg::ResultTdataWidth-1:arpp_pkg::ResultBits]);
	endfunction
endclass

module arp_packet_parser_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // payload_byte [7:0]
	logic s_axis_tlast = 1'b0;       // last_byte
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [arpp_pkg::ResultTdataWidth-1:0] m_axis_tdata;   // verdict item, see result_t

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_sent = 0;
	logic [7:0] frame_q[$];
	verdict_board board = new();

	arp_packet_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// random receiver stalls
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// watch both handshakes; older verdicts are checked before new bytes are noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_verdict(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				board.note_byte(s_axis_tdata, s_axis_tlast);
		end
	end

	// present one byte, idling first now and then, and wait for its handshake
	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_byte(frame_q[i], i == frame_q.size() - 1);
		bytes_sent += frame_q.size();
		frame_q.delete();
	endtask

	// drop valid and hold off until every verdict has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// most significant byte first
	task automatic put_bytes(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			frame_q.insert(frame_q.size(), v[8*i +: 8]);
	endtask

	task automatic put_random(input int n);
		repeat (n) frame_q.insert(frame_q.size(), 8'($urandom));
	endtask

	task automatic put_header(input logic [15:0] ht, input logic [15:0] pt,
			input logic [7:0] hl, input logic [7:0] pl, input logic [15:0] op);
		put_bytes({ht, pt, hl, pl, op}, 8);
	endtask

	task automatic trim_to(input int n);
		while (frame_q.size() > n)
			void'(frame_q.pop_back());
	endtask

	function automatic logic [15:0] pick_opcode();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			return arpp_pkg::OP_REQUEST;
		else if (sel < 60)
			return arpp_pkg::OP_REPLY;
		else if (sel < 80)
			return 16'($urandom_range(3, 25));
		else if (sel < 90)
			return ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(26, 40));
		return 16'($urandom);
	endfunction

	// ethernet/ipv4 frame; sender ip zero, equal to target ip, or free
	task automatic put_eth(input logic [15:0] op, input int sip_mode);
		logic [47:0] smac, tmac;
		logic [31:0] sip, tip;
		smac = 48'({$urandom, $urandom});
		tmac = 48'({$urandom, $urandom});
		tip = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom);
		case (sip_mode)
			0: sip = '0;
			1: sip = tip;
			default: sip = $urandom;
		endcase
		put_header(arpp_pkg::HTYPE_ETHERNET, arpp_pkg::PTYPE_IPV4, arpp_pkg::HLEN_ETHERNET,
			arpp_pkg::PLEN_IPV4, op);
		put_bytes(64'(smac), 6);
		put_bytes(64'(sip), 4);
		put_bytes(64'(tmac), 6);
		put_bytes(64'(tip), 4);
	endtask

	task automatic random_eth();
		int sel;
		put_eth(pick_opcode(), $urandom_range(0, 3));
		sel = $urandom_range(0, 9);
		if (sel == 0)
			trim_to($urandom_range(1, 27));
		else if (sel == 1)
			put_random($urandom_range(1, 12));
	endtask

	// other layouts with address lengths near the frame length
	task automatic random_other();
		logic [15:0] ht, pt;
		logic [7:0] hl, pl;
		int body;
		ht = ($urandom_range(0, 1) != 0) ? arpp_pkg::HTYPE_ETHERNET : 16'($urandom);
		pt = ($urandom_range(0, 1) != 0) ? arpp_pkg::PTYPE_IPV4 : 16'($urandom);
		hl = ($urandom_range(0, 3) == 0) ? arpp_pkg::HLEN_ETHERNET : 8'($urandom_range(0, 8));
		pl = ($urandom_range(0, 3) == 0) ? arpp_pkg::PLEN_IPV4 : 8'($urandom_range(0, 8));
		put_header(ht, pt, hl, pl, pick_opcode());
		body = 2 * int'(hl) + 2 * int'(pl) + int'($urandom_range(0, 6)) - 3;
		if (body < 0)
			trim_to(8 + body);
		else
			put_random(body);
	endtask

	task automatic random_phase(input int s_pct, input int r_pct, input int nbytes);
		int start, sel;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) begin
			sel = $urandom_range(0, 99);
			if (sel < 60)
				random_eth();
			else if (sel < 85)
				random_other();
			else
				put_random($urandom_range(1, 12));
			send_frame();
		end
		drain();
	endtask

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 22;
		recv_idle_pct = 58;

		// one-byte frame
		put_bytes(64'hff, 1);
		send_frame();
		// header only, no addresses needed, highest opcode, all-ones types
		put_header(16'hffff, 16'hffff, 8'd0, 8'd0, arpp_pkg::OP_MAX);
		send_frame();
		// opcode zero and opcode just above the range
		put_header(16'h0000, 16'h0000, 8'd0, 8'd0, 16'd0);
		send_frame();
		put_header(arpp_pkg::HTYPE_ETHERNET, arpp_pkg::PTYPE_IPV4, 8'd0, 8'd0,
			arpp_pkg::OP_MAX + 16'd1);
		send_frame();
		// gratuitous request that is also an announcement
		put_eth(arpp_pkg::OP_REQUEST, 1);
		send_frame();
		// probe
		put_eth(arpp_pkg::OP_REQUEST, 0);
		send_frame();
		// gratuitous reply with all-ones addresses
		put_header(arpp_pkg::HTYPE_ETHERNET, arpp_pkg::PTYPE_IPV4, arpp_pkg::HLEN_ETHERNET,
			arpp_pkg::PLEN_IPV4, arpp_pkg::OP_REPLY);
		put_bytes('1, 6);
		put_bytes('1, 4);
		put_bytes('1, 6);
		put_bytes('1, 4);
		send_frame();
		// ethernet frame one byte short of its addresses
		put_eth(arpp_pkg::OP_REPLY, 2);
		trim_to(27);
		send_frame();
		drain();

		random_phase(22, 58, 200);
		random_phase(58, 22, 200);
		random_phase(0, 0, 200);

		// largest address lengths, exactly long enough
		put_header(16'($urandom), 16'($urandom), 8'd255, 8'd255, 16'($urandom_range(1, 25)));
		put_random(1020);
		send_frame();
		drain();

		$display("%0d bytes in %0d frames checked over three stall mixes and a long frame",
			bytes_sent, board.n_checked);
		$display("%0d accepted, %0d ethernet/ipv4, %0d with kind flags",
			board.n_accepted, board.n_eth, board.n_flagged);
		if (board.n_failed == 0 && board.n_checked == board.n_frames)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
